@@ rtl/core/brd_pkg.sv @@
`timescale 1ns / 1ps

package brd_pkg;

	localparam int DEF_MAX_WIDTH    = 2048;
	localparam int DEF_MAX_HEIGHT   = 4096;
	localparam int RESET_WIDTH      = 640;
	localparam int RESET_HEIGHT     = 480;
	localparam int WIN              = 7;
	localparam int LINES            = WIN - 1;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 13;
	localparam int CFG_WIDTH_BITS   = 12;
	localparam int CFG_HEIGHT_BITS  = 13;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} reg_idx_t;

	typedef struct packed {
		logic             emit;
		logic [WIN-1:0]   row_ok;
		logic [WIN-1:0]   col_ok;
		logic             row_par;
		logic             col_par;
		logic             eol;
		logic             eof;
	} meta_t;

	function automatic logic signed [10:0] lap(input logic [7:0] c, input logic [7:0] a,
			input logic [7:0] b);
		lap = $signed({2'b00, c, 1'b0}) - $signed({3'b000, a}) - $signed({3'b000, b});
	endfunction

	function automatic logic [7:0] rclamp(input logic signed [13:0] n, input logic tie);
		logic signed [13:0] q;
		q = tie ? ((n + 14'sd4) >>> 3) : ((n + 14'sd2) >>> 2);
		if (n < 0) begin
			rclamp = 8'd0;
		end else if (q > 14'sd255) begin
			rclamp = 8'd255;
		end else begin
			rclamp = q[7:0];
		end
	endfunction

	// Pick the direction with the smaller gradient, or blend both on a tie.
	function automatic logic [7:0] ha_est(input logic [7:0] p1, input logic [7:0] p2,
			input logic [7:0] q1, input logic [7:0] q2,
			input logic signed [10:0] l1, input logic signed [10:0] l2);
		logic signed [11:0] dp;
		logic signed [11:0] dq;
		logic signed [11:0] g1;
		logic signed [11:0] g2;
		logic signed [13:0] sp;
		logic signed [13:0] sq;
		dp = $signed({4'b0, p1}) - $signed({4'b0, p2});
		dq = $signed({4'b0, q1}) - $signed({4'b0, q2});
		g1 = (dp < 0 ? -dp : dp) + (l1 < 0 ? -12'(l1) : 12'(l1));
		g2 = (dq < 0 ? -dq : dq) + (l2 < 0 ? -12'(l2) : 12'(l2));
		sp = $signed({5'b0, p1, 1'b0}) + $signed({5'b0, p2, 1'b0});
		sq = $signed({5'b0, q1, 1'b0}) + $signed({5'b0, q2, 1'b0});
		if (g1 < g2) begin
			ha_est = rclamp(sp + 14'(l1), 1'b0);
		end else if (g1 > g2) begin
			ha_est = rclamp(sq + 14'(l2), 1'b0);
		end else begin
			ha_est = rclamp(sp + sq + 14'(l1) + 14'(l2), 1'b1);
		end
	endfunction

	function automatic logic [7:0] green_interp(input logic [7:0] c,
			input logic [7:0] l, input logic [7:0] r, input logic [7:0] u,
			input logic [7:0] d, input logic [7:0] l2, input logic [7:0] r2,
			input logic [7:0] u2, input logic [7:0] d2);
		green_interp = ha_est(l, r, u, d, lap(c, l2, r2), lap(c, u2, d2));
	endfunction

endpackage

@@ rtl/core/brd_if.sv @@
`timescale 1ns / 1ps

interface brd_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] sample;
	modport source (output valid, output mode, output sample, input ready);
	modport sink (input valid, input mode, input sample, output ready);
endinterface

interface brd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       end_of_line;
	logic       end_of_frame;
	modport source (output valid, output red, output green, output blue,
		output end_of_line, output end_of_frame, input ready);
	modport sink (input valid, input red, input green, input blue,
		input end_of_line, input end_of_frame, output ready);
endinterface

interface brd_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [brd_pkg::CFG_IDX_W-1:0]    index;
	logic [brd_pkg::CFG_DATA_W-1:0]   data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/brd_ram.sv @@
`timescale 1ns / 1ps

module brd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/core/bayer_rggb_demosaic.sv @@
`timescale 1ns / 1ps
// A pixel appears once the request 3*frame_width+3 places after its sample, which
// completes its 7x7 neighborhood, has passed the sample, window, green and output
// registers. Throughput: one request per cycle unless stalled, set by the single
// line-store port pair. Reset clears all control state and sets a 640 x 480 frame;
// the line store is not cleared, since only samples of the current frame are used.

module bayer_rggb_demosaic #(
	parameter int MAX_WIDTH  = brd_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = brd_pkg::DEF_MAX_HEIGHT
) (
	input logic          clk,
	input logic          arst_n,
	brd_in_if.sink       pixel_in,
	brd_out_if.source    pixel_out,
	brd_cfg_if.sink      cfg
);

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int LW = $clog2(3 * MAX_WIDTH + 4);
	localparam int N  = brd_pkg::WIN;
	localparam int NL = brd_pkg::LINES;
	localparam int RST_W = brd_pkg::RESET_WIDTH > MAX_WIDTH ? MAX_WIDTH : brd_pkg::RESET_WIDTH;
	localparam int RST_H = brd_pkg::RESET_HEIGHT > MAX_HEIGHT ? MAX_HEIGHT :
		brd_pkg::RESET_HEIGHT;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [LW-1:0] cnt_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [CW-1:0] ptr_q;

	logic [LW-1:0] lead;
	logic          emit_now;
	logic          in_acc;
	logic          cfg_acc;
	brd_pkg::meta_t meta_in;

	logic                 v1, v2, v3, v4;
	logic                 r1, r2, r3, r4;
	logic [7:0]           samp_s1;
	logic [CW-1:0]        ptr_s1;
	brd_pkg::meta_t       meta_s1, meta_s2;
	logic [7:0]           win_s2 [N][N];
	logic [8*NL-1:0]      line_rd;

	logic [7:0] m [N][N];
	logic [7:0] g0_s3, g22_s3, g24_s3, g42_s3, g44_s3;
	logic [7:0] c_s3, m32_s3, m34_s3, m23_s3, m43_s3, m22_s3, m24_s3, m42_s3, m44_s3;
	logic       rp_s3, cp_s3, eol_s3, eof_s3;
	logic [7:0] g0, g22, g24, g42, g44;
	logic [7:0] diag;
	logic [7:0] avg_h, avg_v;
	logic [7:0] red_n, green_n, blue_n;
	logic [13:0] wsat;
	logic [17:0] hsat;

	assign cfg.ready = 1'b1;
	assign cfg_acc = cfg.valid;
	assign in_acc = pixel_in.valid && r1;
	assign pixel_in.ready = r1;

	assign r4 = !v4 || pixel_out.ready;
	assign r3 = !v3 || r4;
	assign r2 = !v2 || r3;
	assign r1 = !v1 || r2;

	assign lead = LW'({width_q, 1'b0}) + LW'(width_q) + LW'(3);
	assign emit_now = cnt_q >= lead;

	always_comb begin
		wsat = 14'(cfg.data[brd_pkg::CFG_WIDTH_BITS-1:0]);
		if (wsat < 14'd2) begin
			wsat = 14'd2;
		end else if (wsat > 14'(MAX_WIDTH)) begin
			wsat = 14'(MAX_WIDTH);
		end
		hsat = 18'(cfg.data[brd_pkg::CFG_HEIGHT_BITS-1:0]);
		if (hsat < 18'd1) begin
			hsat = 18'd1;
		end else if (hsat > 18'(MAX_HEIGHT)) begin
			hsat = 18'(MAX_HEIGHT);
		end
	end

	always_comb begin
		meta_in.emit = emit_now;
		for (int k = 0; k < N; k++) begin
			meta_in.row_ok[k] = (int'(row_q) + k - 3 >= 0) && (int'(row_q) + k - 3 < int'(height_q));
			meta_in.col_ok[k] = (int'(col_q) + k - 3 >= 0) && (int'(col_q) + k - 3 < int'(width_q));
		end
		meta_in.row_par = row_q[0];
		meta_in.col_par = col_q[0];
		meta_in.eol = WW'(col_q) + WW'(1) >= width_q;
		meta_in.eof = meta_in.eol && (HW'(row_q) + HW'(1) >= height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(RST_W);
			height_q <= HW'(RST_H);
			cnt_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			ptr_q    <= '0;
		end else if (cfg_acc) begin
			case (cfg.index)
				brd_pkg::REG_FRAME_WIDTH: begin
					width_q <= wsat[WW-1:0];
				end
				brd_pkg::REG_FRAME_HEIGHT: begin
					height_q <= hsat[HW-1:0];
				end
				default: begin
				end
			endcase
			if (cfg.index == brd_pkg::REG_FRAME_WIDTH || cfg.index == brd_pkg::REG_FRAME_HEIGHT) begin
				cnt_q <= '0;
				row_q <= '0;
				col_q <= '0;
				ptr_q <= '0;
			end
		end else if (in_acc) begin
			ptr_q <= (WW'(ptr_q) + WW'(1) >= width_q) ? '0 : ptr_q + CW'(1);
			if (!emit_now) begin
				cnt_q <= cnt_q + LW'(1);
			end else if (meta_in.eof) begin
				cnt_q <= '0;
				row_q <= '0;
				col_q <= '0;
			end else if (meta_in.eol) begin
				col_q <= '0;
				row_q <= row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Each entry holds the six older lines of one column, newest in the low byte.
	brd_ram #(
		.WIDTH(8 * NL),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (v1 && r2),
		.waddr (ptr_s1),
		.wdata ({line_rd[8*(NL-1)-1:0], samp_s1}),
		.re    (in_acc),
		.raddr (ptr_q),
		.rdata (line_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
		end else begin
			if (r1) begin
				v1 <= in_acc;
			end
			if (r2) begin
				v2 <= v1;
			end
			if (r3) begin
				v3 <= v2 && meta_s2.emit;
			end
			if (r4) begin
				v4 <= v3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			samp_s1 <= pixel_in.mode ? 8'd0 : pixel_in.sample;
			ptr_s1  <= ptr_q;
			meta_s1 <= meta_in;
		end
		if (v1 && r2) begin
			meta_s2 <= meta_s1;
			for (int y = 0; y < N; y++) begin
				for (int x = 0; x < N - 1; x++) begin
					win_s2[y][x] <= win_s2[y][x+1];
				end
			end
			for (int y = 0; y < NL; y++) begin
				win_s2[y][N-1] <= line_rd[8*(NL-1-y) +: 8];
			end
			win_s2[N-1][N-1] <= samp_s1;
		end
	end

	always_comb begin
		for (int y = 0; y < N; y++) begin
			for (int x = 0; x < N; x++) begin
				m[y][x] = (meta_s2.row_ok[y] && meta_s2.col_ok[x]) ? win_s2[y][x] : 8'd0;
			end
		end
		g0  = brd_pkg::green_interp(m[3][3], m[3][2], m[3][4], m[2][3], m[4][3],
			m[3][1], m[3][5], m[1][3], m[5][3]);
		g22 = brd_pkg::green_interp(m[2][2], m[2][1], m[2][3], m[1][2], m[3][2],
			m[2][0], m[2][4], m[0][2], m[4][2]);
		g24 = brd_pkg::green_interp(m[2][4], m[2][3], m[2][5], m[1][4], m[3][4],
			m[2][2], m[2][6], m[0][4], m[4][4]);
		g42 = brd_pkg::green_interp(m[4][2], m[4][1], m[4][3], m[3][2], m[5][2],
			m[4][0], m[4][4], m[2][2], m[6][2]);
		g44 = brd_pkg::green_interp(m[4][4], m[4][3], m[4][5], m[3][4], m[5][4],
			m[4][2], m[4][6], m[2][4], m[6][4]);
	end

	always_ff @(posedge clk) begin
		if (v2 && r3) begin
			g0_s3  <= g0;
			g22_s3 <= (meta_s2.row_ok[2] && meta_s2.col_ok[2]) ? g22 : 8'd0;
			g24_s3 <= (meta_s2.row_ok[2] && meta_s2.col_ok[4]) ? g24 : 8'd0;
			g42_s3 <= (meta_s2.row_ok[4] && meta_s2.col_ok[2]) ? g42 : 8'd0;
			g44_s3 <= (meta_s2.row_ok[4] && meta_s2.col_ok[4]) ? g44 : 8'd0;
			c_s3   <= m[3][3];
			m32_s3 <= m[3][2];
			m34_s3 <= m[3][4];
			m23_s3 <= m[2][3];
			m43_s3 <= m[4][3];
			m22_s3 <= m[2][2];
			m24_s3 <= m[2][4];
			m42_s3 <= m[4][2];
			m44_s3 <= m[4][4];
			rp_s3  <= meta_s2.row_par;
			cp_s3  <= meta_s2.col_par;
			eol_s3 <= meta_s2.eol;
			eof_s3 <= meta_s2.eof;
		end
	end

	always_comb begin
		logic [8:0] sh;
		logic [8:0] sv;
		diag = brd_pkg::ha_est(m22_s3, m44_s3, m24_s3, m42_s3,
			brd_pkg::lap(g0_s3, g22_s3, g44_s3), brd_pkg::lap(g0_s3, g24_s3, g42_s3));
		sh = {1'b0, m32_s3} + {1'b0, m34_s3};
		sv = {1'b0, m23_s3} + {1'b0, m43_s3};
		avg_h = sh[8:1];
		avg_v = sv[8:1];
		case ({rp_s3, cp_s3})
			2'b00: begin
				red_n = c_s3;
				green_n = g0_s3;
				blue_n = diag;
			end
			2'b11: begin
				red_n = diag;
				green_n = g0_s3;
				blue_n = c_s3;
			end
			2'b01: begin
				red_n = avg_h;
				green_n = c_s3;
				blue_n = avg_v;
			end
			default: begin
				red_n = avg_v;
				green_n = c_s3;
				blue_n = avg_h;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (v3 && r4) begin
			pixel_out.red          <= red_n;
			pixel_out.green        <= green_n;
			pixel_out.blue         <= blue_n;
			pixel_out.end_of_line  <= eol_s3;
			pixel_out.end_of_frame <= eof_s3;
		end
	end

	assign pixel_out.valid = v4;

endmodule

@@ rtl/core/brd_checker.sv @@
`timescale 1ns / 1ps

module brd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue,
	input logic       end_of_line,
	input logic       end_of_frame
);

	logic last_eol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_eol_q <= 1'b0;
		end else if (out_valid && out_ready) begin
			last_eol_q <= end_of_line;
		end
	end

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pixel request dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable({red, green, blue, end_of_line, end_of_frame}))
		else $error("pixel payload changed while stalled");

	a_eof_is_eol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!end_of_frame || end_of_line))
		else $error("end of frame without end of line");

	// Lines hold at least two pixels, so two line ends never follow each other.
	a_no_double_eol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_eol_q |-> !end_of_line)
		else $error("two consecutive pixels closed a line");

endmodule

bind bayer_rggb_demosaic brd_checker u_brd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (pixel_out.valid),
	.out_ready    (pixel_out.ready),
	.red          (pixel_out.red),
	.green        (pixel_out.green),
	.blue         (pixel_out.blue),
	.end_of_line  (pixel_out.end_of_line),
	.end_of_frame (pixel_out.end_of_frame)
);

@@ verif/bayer_rggb_demosaic_test.sv @@
`timescale 1ns / 1ps

module bayer_rggb_demosaic_test;

	localparam int RING = 8 * brd_pkg::DEF_MAX_WIDTH;
	localparam int DW = brd_pkg::CFG_DATA_W;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       eol;
		logic       eof;
	} pixel_t;

	typedef struct packed {
		logic       mode;
		logic [7:0] sample;
		logic       typed;
		pixel_t     pix;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	brd_in_if  in_if();
	brd_out_if out_if();
	brd_cfg_if cfg_if();

	bayer_rggb_demosaic dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel_in  (in_if),
		.pixel_out (out_if),
		.cfg       (cfg_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	pixel_t     pixel_q[$];
	int         errors = 0;
	int         pixels_seen = 0;
	logic [7:0] raw_mem[RING];
	int         win[7][7];
	bit         win_ok[7][7];
	int         width_cur, height_cur, frame_pos, row_pos, col_pos;
	int         burst_left = 0;
	bit         hold_req = 1'b0;

	function automatic int round_sat(int n, int sh);
		int h;
		int q;
		h = 1 << (sh - 1);
		q = n >= 0 ? (n + h) >>> sh : -(((-n) + h) >>> sh);
		if (q < 0) q = 0;
		if (q > 255) q = 255;
		return q;
	endfunction

	function automatic int iabs(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic int est_green(int y, int x);
		int c, gl, gr, gu, gd, lh, lv, hg, vg;
		c = win[y][x];
		gl = win[y][x-1];
		gr = win[y][x+1];
		gu = win[y-1][x];
		gd = win[y+1][x];
		lh = 2 * c - win[y][x-2] - win[y][x+2];
		lv = 2 * c - win[y-2][x] - win[y+2][x];
		hg = iabs(gl - gr) + iabs(lh);
		vg = iabs(gu - gd) + iabs(lv);
		if (hg < vg) return round_sat(2 * (gl + gr) + lh, 2);
		if (hg > vg) return round_sat(2 * (gu + gd) + lv, 2);
		return round_sat(2 * (gl + gr + gu + gd) + lh + lv, 3);
	endfunction

	function automatic int green_site(int y, int x);
		if (!win_ok[y][x]) return 0;
		if (((row_pos + y + 1) & 1) != ((col_pos + x + 1) & 1)) return win[y][x];
		return est_green(y, x);
	endfunction

	function automatic int est_diag();
		int g0, ca, cb, cc, cd, la, lb, d1, d2;
		g0 = est_green(3, 3);
		ca = win[2][2];
		cb = win[4][4];
		cc = win[2][4];
		cd = win[4][2];
		la = 2 * g0 - green_site(2, 2) - green_site(4, 4);
		lb = 2 * g0 - green_site(2, 4) - green_site(4, 2);
		d1 = iabs(ca - cb) + iabs(la);
		d2 = iabs(cc - cd) + iabs(lb);
		if (d1 < d2) return round_sat(2 * (ca + cb) + la, 2);
		if (d1 > d2) return round_sat(2 * (cc + cd) + lb, 2);
		return round_sat(2 * (ca + cb + cc + cd) + la + lb, 3);
	endfunction

	function automatic void predict_pixel(logic mode, logic [7:0] sample);
		int t, rr, cc;
		pixel_t p;
		t = frame_pos;
		if (t < width_cur * height_cur) raw_mem[t % RING] = mode ? 8'd0 : sample;
		frame_pos = t + 1;
		if (t < 3 * width_cur + 3) return;
		for (int y = 0; y < 7; y++) begin
			for (int x = 0; x < 7; x++) begin
				rr = row_pos + y - 3;
				cc = col_pos + x - 3;
				win_ok[y][x] = rr >= 0 && rr < height_cur && cc >= 0 && cc < width_cur;
				win[y][x] = win_ok[y][x] ? raw_mem[(rr * width_cur + cc) % RING] : 0;
			end
		end
		if (!row_pos[0] && !col_pos[0]) begin
			p.red = 8'(win[3][3]);
			p.green = 8'(est_green(3, 3));
			p.blue = 8'(est_diag());
		end else if (row_pos[0] && col_pos[0]) begin
			p.red = 8'(est_diag());
			p.green = 8'(est_green(3, 3));
			p.blue = 8'(win[3][3]);
		end else if (!row_pos[0]) begin
			p.red = 8'((win[3][2] + win[3][4]) >> 1);
			p.green = 8'(win[3][3]);
			p.blue = 8'((win[2][3] + win[4][3]) >> 1);
		end else begin
			p.red = 8'((win[2][3] + win[4][3]) >> 1);
			p.green = 8'(win[3][3]);
			p.blue = 8'((win[3][2] + win[3][4]) >> 1);
		end
		p.eol = col_pos + 1 >= width_cur;
		p.eof = p.eol && row_pos + 1 >= height_cur;
		pixel_q.push_back(p);
		if (p.eof) begin
			frame_pos = 0;
			row_pos = 0;
			col_pos = 0;
		end else if (p.eol) begin
			col_pos = 0;
			row_pos++;
		end else begin
			col_pos++;
		end
	endfunction

	task automatic send_sample(logic mode, logic [7:0] sample);
		in_if.valid <= 1'b1;
		in_if.mode <= mode;
		in_if.sample <= sample;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		predict_pixel(mode, sample);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(100, 300) : $urandom_range(0, 30);
		end
	endtask

	task automatic drain_wait();
		in_if.valid <= 1'b0;
		@(posedge clk);
		wait (pixel_q.size() == 0);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(brd_pkg::reg_idx_t idx, int value);
		int v;
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= DW'(value);
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		cfg_if.valid <= 1'b0;
		if (idx == brd_pkg::REG_FRAME_WIDTH) begin
			v = value & 12'hFFF;
			width_cur = v < 2 ? 2 : (v > brd_pkg::DEF_MAX_WIDTH ? brd_pkg::DEF_MAX_WIDTH : v);
		end else begin
			v = value & 13'h1FFF;
			height_cur = v < 1 ? 1 :
				(v > brd_pkg::DEF_MAX_HEIGHT ? brd_pkg::DEF_MAX_HEIGHT : v);
		end
		frame_pos = 0;
		row_pos = 0;
		col_pos = 0;
		@(posedge clk);
	endtask

	task automatic run_frame(int frac_kept, bit noisy);
		int total, count;
		total = width_cur * height_cur;
		count = (total + 3 * width_cur + 3) * frac_kept / 100;
		for (int i = 0; i < count; i++) begin
			if (i < total)
				send_sample(noisy && $urandom_range(0, 30) == 0, 8'($urandom_range(0, 255)));
			else if (noisy && $urandom_range(0, 4) == 0)
				send_sample(1'b0, 8'($urandom_range(0, 255)));
			else
				send_sample(1'b1, 8'($urandom_range(0, 255)));
		end
	endtask

	function automatic void check_field(string name, int e, int a);
		if (e != a) begin
			$display("%0t mismatch %s: expected %0d actual %0d", $time, name, e, a);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (out_if.valid && out_if.ready) begin
			if (pixel_q.size() == 0) begin
				$display("%0t unexpected pixel: expected none actual %0d %0d %0d", $time,
					out_if.red, out_if.green, out_if.blue);
				errors++;
			end else begin
				pixel_t e;
				e = pixel_q.pop_front();
				check_field("red", e.red, out_if.red);
				check_field("green", e.green, out_if.green);
				check_field("blue", e.blue, out_if.blue);
				check_field("end_of_line", e.eol, out_if.end_of_line);
				check_field("end_of_frame", e.eof, out_if.end_of_frame);
			end
			pixels_seen++;
		end
	end

	initial begin
		int hold_cnt;
		int style;
		hold_cnt = 0;
		style = 0;
		out_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0) style = $urandom_range(0, 2);
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_if.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 400;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= style == 0 ? 1'b1 :
					(style == 1 ? $urandom_range(0, 3) != 0 : $urandom_range(0, 3) == 0);
			end
		end
	end

	initial begin
		dir_row_t dir_tab[$];
		int items;
		int frames;
		in_if.valid = 1'b0;
		in_if.mode = 1'b0;
		in_if.sample = 8'd0;
		cfg_if.valid = 1'b0;
		cfg_if.index = brd_pkg::REG_FRAME_WIDTH;
		cfg_if.data = '0;
		width_cur = brd_pkg::RESET_WIDTH;
		height_cur = brd_pkg::RESET_HEIGHT;
		frame_pos = 0;
		row_pos = 0;
		col_pos = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// An all-zero two-pixel frame, then one with a drain inside the frame and two
		// samples after its end.
		dir_tab = '{
			'{1'b0, 8'h00, 1'b0, '0}, '{1'b0, 8'h00, 1'b0, '0},
			'{1'b1, 8'h00, 1'b0, '0}, '{1'b1, 8'hFF, 1'b0, '0},
			'{1'b1, 8'h00, 1'b0, '0}, '{1'b1, 8'h00, 1'b0, '0},
			'{1'b1, 8'h00, 1'b0, '0}, '{1'b1, 8'h00, 1'b0, '0},
			'{1'b1, 8'h00, 1'b0, '0},
			'{1'b1, 8'h00, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b0, 1'b0}},
			'{1'b1, 8'h00, 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1, 1'b1}},
			'{1'b0, 8'hFF, 1'b0, '0}, '{1'b1, 8'h33, 1'b0, '0},
			'{1'b0, 8'hA5, 1'b0, '0}, '{1'b1, 8'hFF, 1'b0, '0},
			'{1'b1, 8'h00, 1'b0, '0}, '{1'b1, 8'h00, 1'b0, '0},
			'{1'b1, 8'h00, 1'b0, '0}, '{1'b1, 8'h00, 1'b0, '0},
			'{1'b1, 8'h00, 1'b0, '0}, '{1'b0, 8'h5A, 1'b0, '0},
			'{1'b1, 8'h00, 1'b0, '0}
		};
		write_reg(brd_pkg::REG_FRAME_WIDTH, 1);
		write_reg(brd_pkg::REG_FRAME_HEIGHT, 0);
		foreach (dir_tab[i]) begin
			send_sample(dir_tab[i].mode, dir_tab[i].sample);
			if (dir_tab[i].typed) pixel_q[pixel_q.size() - 1] = dir_tab[i].pix;
		end
		drain_wait();

		write_reg(brd_pkg::REG_FRAME_WIDTH, 4095);
		write_reg(brd_pkg::REG_FRAME_HEIGHT, 1);
		run_frame(2, 1'b0);
		drain_wait();
		write_reg(brd_pkg::REG_FRAME_WIDTH, 0);
		write_reg(brd_pkg::REG_FRAME_HEIGHT, 8191);
		run_frame(1, 1'b1);
		drain_wait();

		items = 0;
		frames = 0;
		while (items < 1300) begin
			if (frames == 0 || $urandom_range(0, 9) < 7) begin
				drain_wait();
				if ($urandom_range(0, 9) == 0)
					write_reg(brd_pkg::REG_FRAME_WIDTH, 2 * $urandom_range(1, 5) + 1);
				else
					write_reg(brd_pkg::REG_FRAME_WIDTH, 2 * $urandom_range(1, 8));
				write_reg(brd_pkg::REG_FRAME_HEIGHT, $urandom_range(1, 8));
			end
			if (frames == 4) begin
				drain_wait();
				write_reg(brd_pkg::REG_FRAME_WIDTH, 16);
				write_reg(brd_pkg::REG_FRAME_HEIGHT, 8);
				hold_req = 1'b1;
			end
			if (frames == 6) begin
				run_frame(50, 1'b1);
				drain_wait();
				items += (width_cur * height_cur + 3 * width_cur + 3) / 2;
				write_reg(brd_pkg::REG_FRAME_HEIGHT, height_cur);
			end
			if ($urandom_range(0, 19) == 0) begin
				run_frame($urandom_range(10, 90), 1'b1);
			end else begin
				run_frame(100, $urandom_range(0, 1));
			end
			items += width_cur * height_cur + 3 * width_cur + 3;
			frames++;
		end

		drain_wait();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
